FILE: hdl/rcrp_pkg.sv
// ----------------------------------------------------------------------------
// rcrp_pkg
// Shared constants and time-coding functions for the RTC register port.
// ----------------------------------------------------------------------------
package rcrp_pkg;

    localparam int IN_TUSER_W  = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    localparam logic [7:0] REG_SEC   = 8'h00;
    localparam logic [7:0] REG_MIN   = 8'h02;
    localparam logic [7:0] REG_HOUR  = 8'h04;
    localparam logic [7:0] REG_WDAY  = 8'h06;
    localparam logic [7:0] REG_DAY   = 8'h07;
    localparam logic [7:0] REG_MONTH = 8'h08;
    localparam logic [7:0] REG_YEAR  = 8'h09;
    localparam logic [7:0] REG_A     = 8'h0A;
    localparam logic [7:0] REG_B     = 8'h0B;
    localparam logic [7:0] REG_C     = 8'h0C;
    localparam logic [7:0] REG_D     = 8'h0D;

    localparam logic [7:0] REG_A_MASK   = 8'h7F;
    localparam logic [7:0] REG_D_VALUE  = 8'h80;
    localparam logic [7:0] PM_FLAG      = 8'h80;
    localparam logic [7:0] INDEX_READ   = 8'hFF;
    localparam logic [7:0] WRITE_RESULT = 8'h00;

    // v / 10 through multiply by 205 and shift by 11, exact for every 7-bit v
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 15'(v) * 15'd205;
        q    = prod[14:11];
        r    = v - 7'({3'b000, q} * 7'd10);
        return {q, r[3:0]};
    endfunction

    function automatic logic [7:0] code_val(input logic [6:0] v, input logic bcd);
        return bcd ? to_bcd(v) : {1'b0, v};
    endfunction

endpackage

FILE: hdl/rtc_cmos_register_port.sv
// Result path: each accepted access is registered in stage 1, then in the output register.
// Throughput: one access per cycle if output is not stalled; one store access at most.
// The store is one synchronous memory; a per-entry valid vector makes unwritten
// entries read as their reset value, so no clearing pass runs after reset.
// Reset: synchronous, active low; clears index, mode copy, valid bits and stage valid flags.
// ----------------------------------------------------------------------------
// rtc_cmos_register_port
// Index/data register port of a real-time clock with a 64-byte CMOS store.
// ----------------------------------------------------------------------------
module rtc_cmos_register_port
    import rcrp_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // func, port_select
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // write_data[7:0], now_second[5:0], now_minute[5:0], now_hour[4:0],
    // now_weekday[2:0], now_day[4:0], now_month[3:0], now_year[6:0]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_data[7:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(STORE_DEPTH);

    logic       w_func;
    logic       w_port;
    logic [7:0] w_wdata;
    logic [5:0] w_sec;
    logic [5:0] w_min;
    logic [4:0] w_hour;
    logic [2:0] w_wday;
    logic [4:0] w_day;
    logic [3:0] w_month;
    logic [6:0] w_year;

    assign w_func  = s_axis_tuser[0];
    assign w_port  = s_axis_tuser[1];
    assign w_wdata = s_axis_tdata[7:0];
    assign w_sec   = s_axis_tdata[13:8];
    assign w_min   = s_axis_tdata[19:14];
    assign w_hour  = s_axis_tdata[24:20];
    assign w_wday  = s_axis_tdata[27:25];
    assign w_day   = s_axis_tdata[32:28];
    assign w_month = s_axis_tdata[36:33];
    assign w_year  = s_axis_tdata[43:37];

    logic [7:0]             r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [IDX_W-1:0]       r_sel;
    logic [7:0]             r_reg_b;
    logic [7:0]             r_rd_data;
    logic                   r_s1_vld;
    logic                   r_s1_mem;
    logic                   r_s1_hit;
    logic [7:0]             r_s1_val;
    logic                   r_out_vld;
    logic [7:0]             r_out_data;

    logic       w_accept;
    logic       w_s1_adv;
    logic       w_store_wr;
    logic       w_store_rd;
    logic [7:0] w_store_val;
    logic       w_bcd;
    logic       w_twelve;
    logic       w_pm;
    logic [4:0] w_h12;
    logic [4:0] w_hsel;
    logic [7:0] w_hcode;
    logic [2:0] w_wcode;
    logic [7:0] w_time_val;
    logic [7:0] w_s1_val;
    logic       w_n_s1_mem;
    logic [7:0] w_n_s1_val;

    assign w_s1_adv      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_store_wr = w_accept && (w_func == FUNC_WRITE) && (w_port == PORT_DATA)
                        && (r_sel >= IDX_W'(REG_A));
    assign w_store_rd = w_accept && (w_func == FUNC_READ) && (w_port == PORT_DATA);

    always_comb begin
        case (r_sel)
            IDX_W'(REG_A): w_store_val = w_wdata & REG_A_MASK;
            IDX_W'(REG_C): w_store_val = 8'h00;
            IDX_W'(REG_D): w_store_val = REG_D_VALUE;
            default:       w_store_val = w_wdata;
        endcase
    end

    // time registers, coded from the current inputs
    assign w_bcd    = !r_reg_b[2];
    assign w_twelve = !r_reg_b[1];
    assign w_pm     = w_twelve && (w_hour >= 5'd12);

    always_comb begin
        if (w_hour >= 5'd24) begin
            w_h12 = w_hour - 5'd24;
        end else if (w_hour >= 5'd12) begin
            w_h12 = w_hour - 5'd12;
        end else begin
            w_h12 = w_hour;
        end
        if (w_h12 == 5'd0) begin
            w_h12 = 5'd12;
        end
    end

    assign w_hsel  = w_twelve ? w_h12 : w_hour;
    assign w_hcode = code_val({2'b00, w_hsel}, w_bcd) | (w_pm ? PM_FLAG : 8'h00);
    assign w_wcode = ((w_wday == 3'd0) || (w_wday == 3'd7)) ? 3'd7 : w_wday;

    always_comb begin
        case (r_sel)
            IDX_W'(REG_SEC):   w_time_val = code_val({1'b0, w_sec}, w_bcd);
            IDX_W'(REG_MIN):   w_time_val = code_val({1'b0, w_min}, w_bcd);
            IDX_W'(REG_HOUR):  w_time_val = w_hcode;
            IDX_W'(REG_WDAY):  w_time_val = {5'b00000, w_wcode};
            IDX_W'(REG_DAY):   w_time_val = code_val({2'b00, w_day}, w_bcd);
            IDX_W'(REG_MONTH): w_time_val = code_val({3'b000, w_month}, w_bcd);
            IDX_W'(REG_YEAR):  w_time_val = code_val(w_year, w_bcd);
            default:           w_time_val = 8'h00;
        endcase
    end

    always_comb begin
        w_n_s1_mem = 1'b0;
        w_n_s1_val = WRITE_RESULT;
        if (w_func == FUNC_READ) begin
            if (w_port == PORT_INDEX) begin
                w_n_s1_val = INDEX_READ;
            end else if (r_sel < IDX_W'(REG_A)) begin
                w_n_s1_val = w_time_val;
            end else begin
                w_n_s1_mem = 1'b1;
                w_n_s1_val = (r_sel == IDX_W'(REG_D)) ? REG_D_VALUE : 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            r_mem[r_sel] <= w_store_val;
        end
        if (w_store_rd) begin
            r_rd_data <= r_mem[r_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_sel   <= '0;
            r_reg_b <= 8'h00;
        end else begin
            if (w_store_wr) begin
                r_vld[r_sel] <= 1'b1;
                if (r_sel == IDX_W'(REG_B)) begin
                    r_reg_b <= w_store_val;
                end
            end
            if (w_accept && (w_func == FUNC_WRITE) && (w_port == PORT_INDEX)) begin
                r_sel <= w_wdata[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mem <= w_n_s1_mem;
            r_s1_hit <= r_vld[r_sel];
            r_s1_val <= w_n_s1_val;
        end
    end

    assign w_s1_val = (r_s1_mem && r_s1_hit) ? r_rd_data : r_s1_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_vld) begin
            r_out_data <= w_s1_val;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: hdl/rcrp_checker.sv
// ----------------------------------------------------------------------------
// rcrp_checker
// Port-level checks for the RTC register port.
// ----------------------------------------------------------------------------
module rcrp_checker
    import rcrp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_WRITE))
        ##1 m_axis_tready |=> m_axis_tvalid && (m_axis_tdata == WRITE_RESULT))
        else $error("write transfer did not return zero");

    a_index_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_READ)
         && (s_axis_tuser[1] == PORT_INDEX))
        ##1 m_axis_tready |=> m_axis_tvalid && (m_axis_tdata == INDEX_READ))
        else $error("index port read did not return all ones");

endmodule

bind rtc_cmos_register_port rcrp_checker u_rcrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
